// ===== hw/rtl/tkct_pkg.sv =====
// shared types and constants for the top-k ranking block
// no dependencies
package tkct_pkg;

    localparam int KEY_W      = 12;
    localparam int COUNT_W    = 31;
    localparam int TIME_W     = 63;
    localparam int LIMIT_W    = 7;
    localparam int RANK_W     = 6;
    localparam int MAX_KEPT_D = 64;

    localparam logic [LIMIT_W-1:0] LIMIT_RST = 7'd10;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  tstamp;
    } t_rec;

    typedef struct packed {
        logic ins;
        logic pop;
        logic clr;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } t_state;

endpackage

// ===== hw/rtl/tkct_cell.sv =====
// one slot of the sorted chain: holds a record; inserts, shifts or clears as the controls say
// depends on tkct_pkg
module tkct_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tkct_pkg::t_cell_ctl i_ctl,
    input  tkct_pkg::t_rec     i_new,
    input  logic               i_prev_valid,
    input  tkct_pkg::t_rec     i_prev,
    input  logic               i_prev_above,
    input  logic               i_next_valid,
    input  tkct_pkg::t_rec     i_next,
    output logic               o_valid,
    output tkct_pkg::t_rec     o_rec,
    output logic               o_above
);
    import tkct_pkg::*;

    logic r_valid;
    logic n_valid;
    t_rec r_rec;
    t_rec n_rec;

    // new record ranks strictly above this slot, or the slot is empty
    assign o_above = !r_valid
                   || (i_new.count > r_rec.count)
                   || ((i_new.count == r_rec.count) && (i_new.tstamp > r_rec.tstamp));

    always_comb begin
        n_valid = r_valid;
        n_rec   = r_rec;
        if (i_ctl.clr) begin
            n_valid = 1'b0;
        end else if (i_ctl.pop) begin
            n_valid = i_next_valid;
            n_rec   = i_next;
        end else if (i_ctl.ins) begin
            if (i_prev_above) begin
                n_valid = i_prev_valid;
                n_rec   = i_prev;
            end else if (o_above) begin
                n_valid = 1'b1;
                n_rec   = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

    assign o_valid = r_valid;
    assign o_rec   = r_rec;

endmodule

// ===== hw/rtl/top_k_by_count_then_time.sv =====
// top level of the top-k ranking block: control, counters and the cell chain
// depends on tkct_pkg and tkct_cell
//
// Records enter one per cycle while busy is low; a record with a zero play count
// is dropped. Each kept record is placed into a chain of MAX_KEPT cells, ordered
// by count then by later time, earlier arrival first on ties. An item with
// end_of_set raises busy from the next cycle and the run is emitted from the
// head of the chain, one result per cycle, each shown for one cycle on o_strobe:
// min(stored, result_limit, MAX_KEPT) results, or one empty marker. The receiver
// cannot stall, so it must take a beat on every strobe. Busy drops the cycle
// after the last result.
module top_k_by_count_then_time #(
    parameter int MAX_KEPT = tkct_pkg::MAX_KEPT_D
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_has_record,
    input  logic [tkct_pkg::KEY_W-1:0]    i_track_key,
    input  logic [tkct_pkg::COUNT_W-1:0]  i_play_count,
    input  logic [tkct_pkg::TIME_W-1:0]   i_last_played,
    input  logic                          i_end_of_set,
    input  logic                          i_cfg_we,
    input  logic [tkct_pkg::LIMIT_W-1:0]  i_cfg_data,
    output logic                          o_strobe,
    output logic [tkct_pkg::RANK_W-1:0]   o_rank,
    output logic [tkct_pkg::KEY_W-1:0]    o_out_key,
    output logic [tkct_pkg::COUNT_W-1:0]  o_out_count,
    output logic [tkct_pkg::TIME_W-1:0]   o_out_time,
    output logic                          o_is_empty,
    output logic                          o_last_of_run
);
    import tkct_pkg::*;

    localparam logic [LIMIT_W-1:0] MAX_K = LIMIT_W'(MAX_KEPT);

    t_state              r_state;
    t_state              n_state;
    logic [LIMIT_W-1:0]  r_limit;
    logic [LIMIT_W-1:0]  r_total;
    logic [LIMIT_W-1:0]  n_total;
    logic [LIMIT_W-1:0]  r_n;
    logic [LIMIT_W-1:0]  n_n;
    logic [RANK_W-1:0]   r_rank;
    logic [RANK_W-1:0]   n_rank;

    logic                accept;
    logic                do_ins;
    logic                emit_last;
    logic [LIMIT_W-1:0]  lim_sat;
    logic [LIMIT_W-1:0]  total_after;
    t_cell_ctl           ctl;
    t_rec                new_rec;

    logic                valid_a [MAX_KEPT];
    t_rec                rec_a   [MAX_KEPT];
    logic                above_a [MAX_KEPT];

    assign busy    = (r_state == S_EMIT);
    assign accept  = start && !busy;
    assign do_ins  = accept && i_has_record && (i_play_count != '0);
    assign new_rec = '{key: i_track_key, count: i_play_count, tstamp: i_last_played};

    assign emit_last = (r_n == '0) || (({1'b0, r_rank} + LIMIT_W'(1)) == r_n);

    assign ctl.ins = do_ins;
    assign ctl.pop = busy && !emit_last;
    assign ctl.clr = busy && emit_last;

    assign lim_sat     = (r_limit > MAX_K) ? MAX_K : r_limit;
    assign total_after = (do_ins && (r_total < MAX_K)) ? r_total + LIMIT_W'(1) : r_total;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_KEPT; gi++) begin : g_cell
            logic prev_valid;
            t_rec prev_rec;
            logic prev_above;
            logic next_valid;
            t_rec next_rec;
            if (gi == 0) begin : g_head
                assign prev_valid = 1'b0;
                assign prev_rec   = '0;
                assign prev_above = 1'b0;
            end else begin : g_mid
                assign prev_valid = valid_a[gi-1];
                assign prev_rec   = rec_a[gi-1];
                assign prev_above = above_a[gi-1];
            end
            if (gi == MAX_KEPT - 1) begin : g_tail
                assign next_valid = 1'b0;
                assign next_rec   = '0;
            end else begin : g_body
                assign next_valid = valid_a[gi+1];
                assign next_rec   = rec_a[gi+1];
            end
            tkct_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (ctl),
                .i_new        (new_rec),
                .i_prev_valid (prev_valid),
                .i_prev       (prev_rec),
                .i_prev_above (prev_above),
                .i_next_valid (next_valid),
                .i_next       (next_rec),
                .o_valid      (valid_a[gi]),
                .o_rec        (rec_a[gi]),
                .o_above      (above_a[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        n_total = r_total;
        n_n     = r_n;
        n_rank  = r_rank;
        unique case (r_state)
            S_IDLE: begin
                n_total = total_after;
                if (accept && i_end_of_set) begin
                    n_state = S_EMIT;
                    n_rank  = '0;
                    n_n     = (total_after < lim_sat) ? total_after : lim_sat;
                end
            end
            S_EMIT: begin
                if (emit_last) begin
                    n_state = S_IDLE;
                    n_total = '0;
                end else begin
                    n_rank = r_rank + RANK_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_limit <= LIMIT_RST;
            r_n     <= '0;
            r_rank  <= '0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_n     <= n_n;
            r_rank  <= n_rank;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    // head cell is the current beat while emitting
    assign o_strobe      = busy;
    assign o_is_empty    = (r_n == '0);
    assign o_last_of_run = emit_last;
    assign o_rank        = o_is_empty ? '0 : r_rank;
    assign o_out_key     = o_is_empty ? '0 : rec_a[0].key;
    assign o_out_count   = o_is_empty ? '0 : rec_a[0].count;
    assign o_out_time    = o_is_empty ? '0 : rec_a[0].tstamp;

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= MAX_K)
        else $error("stored count above chain length");

    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_end_of_set |=> o_strobe && (r_rank == '0))
        else $error("end item did not start a run at rank zero");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last_of_run |=> !busy && (r_total == '0))
        else $error("run end did not clear the store");

    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_is_empty |-> valid_a[0])
        else $error("ranked beat from an empty head cell");

    a_n_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_n <= MAX_K) && (r_n <= $past(r_limit)))
        else $error("run length above limit");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// testbench for top_k_by_count_then_time: directed and random record runs,
// predicted by a scoreboard class holding its own ranked store
// depends on tkct_pkg and the top_k_by_count_then_time rtl
module tb;
    import tkct_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [TIME_W-1:0]  TIME_MAX  = '1;

    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  tstamp;
        logic               is_empty;
        logic               last_of_run;
    } t_ranked;

    class ranking_board;
        logic [COUNT_W-1:0] kept_count [MAX_KEPT_D];
        logic [TIME_W-1:0]  kept_time  [MAX_KEPT_D];
        logic [KEY_W-1:0]   kept_key   [MAX_KEPT_D];
        int                 kept_total;
        logic [LIMIT_W-1:0] limit;
        t_ranked            ranked_due [$];
        int                 errors;

        function new();
            kept_total = 0;
            limit      = LIMIT_RST;
            errors     = 0;
        endfunction

        function void set_limit(logic [LIMIT_W-1:0] v);
            limit = v;
        endfunction

        function int pending();
            return ranked_due.size();
        endfunction

        // insert one accepted beat, emit the ranked run on an end mark
        function void take_track(logic has, logic [KEY_W-1:0] key,
                                 logic [COUNT_W-1:0] cnt, logic [TIME_W-1:0] tm,
                                 logic eos);
            int pos;
            int last;
            int i;
            int lim;
            int n;
            t_ranked r;
            if (has && cnt != 0) begin
                pos = 0;
                while (pos < kept_total &&
                       !(cnt > kept_count[pos] ||
                         (cnt == kept_count[pos] && tm > kept_time[pos])))
                    pos++;
                if (pos < MAX_KEPT_D) begin
                    last = (kept_total < MAX_KEPT_D) ? kept_total : MAX_KEPT_D - 1;
                    for (i = last; i > pos; i--) begin
                        kept_count[i] = kept_count[i-1];
                        kept_time[i]  = kept_time[i-1];
                        kept_key[i]   = kept_key[i-1];
                    end
                    kept_count[pos] = cnt;
                    kept_time[pos]  = tm;
                    kept_key[pos]   = key;
                    if (kept_total < MAX_KEPT_D)
                        kept_total++;
                end
            end
            if (!eos)
                return;
            lim = (limit > MAX_KEPT_D) ? MAX_KEPT_D : int'(limit);
            n = (kept_total < lim) ? kept_total : lim;
            if (n == 0) begin
                r = '0;
                r.is_empty    = 1'b1;
                r.last_of_run = 1'b1;
                ranked_due = {ranked_due, r};
            end else begin
                for (i = 0; i < n; i++) begin
                    r.rank        = i[RANK_W-1:0];
                    r.key         = kept_key[i];
                    r.count       = kept_count[i];
                    r.tstamp      = kept_time[i];
                    r.is_empty    = 1'b0;
                    r.last_of_run = (i == n - 1);
                    ranked_due = {ranked_due, r};
                end
            end
            kept_total = 0;
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void match_ranked(t_ranked got);
            t_ranked want;
            if (ranked_due.size() == 0) begin
                $error("result beat with nothing expected: key 0x%0h", got.key);
                errors++;
                return;
            end
            want = ranked_due.pop_front();
            check_field("rank", 64'(want.rank), 64'(got.rank));
            check_field("out_key", 64'(want.key), 64'(got.key));
            check_field("out_count", 64'(want.count), 64'(got.count));
            check_field("out_time", 64'(want.tstamp), 64'(got.tstamp));
            check_field("is_empty", 64'(want.is_empty), 64'(got.is_empty));
            check_field("last_of_run", 64'(want.last_of_run), 64'(got.last_of_run));
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_has_record;
    logic [KEY_W-1:0]    i_track_key;
    logic [COUNT_W-1:0]  i_play_count;
    logic [TIME_W-1:0]   i_last_played;
    logic                i_end_of_set;
    logic                i_cfg_we;
    logic [LIMIT_W-1:0]  i_cfg_data;
    logic                o_strobe;
    logic [RANK_W-1:0]   o_rank;
    logic [KEY_W-1:0]    o_out_key;
    logic [COUNT_W-1:0]  o_out_count;
    logic [TIME_W-1:0]   o_out_time;
    logic                o_is_empty;
    logic                o_last_of_run;

    ranking_board sb = new();
    int           idle_cycles = 0;
    int           item_beats;

    top_k_by_count_then_time DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_has_record  (i_has_record),
        .i_track_key   (i_track_key),
        .i_play_count  (i_play_count),
        .i_last_played (i_last_played),
        .i_end_of_set  (i_end_of_set),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_strobe      (o_strobe),
        .o_rank        (o_rank),
        .o_out_key     (o_out_key),
        .o_out_count   (o_out_count),
        .o_out_time    (o_out_time),
        .o_is_empty    (o_is_empty),
        .o_last_of_run (o_last_of_run)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin : result_mon
        t_ranked got;
        if (i_rst_n && o_strobe) begin
            got.rank        = o_rank;
            got.key         = o_out_key;
            got.count       = o_out_count;
            got.tstamp      = o_out_time;
            got.is_empty    = o_is_empty;
            got.last_of_run = o_last_of_run;
            sb.match_ranked(got);
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic logic [COUNT_W-1:0] draw_count();
        logic [31:0] v;
        int sel;
        v = $urandom;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel <= 5)
            return COUNT_W'($urandom_range(1, 4));
        if (sel == 9)
            return COUNT_MAX;
        return v[COUNT_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] draw_time();
        logic [63:0] v;
        v = {$urandom, $urandom};
        if ($urandom_range(0, 1) == 0)
            return TIME_W'($urandom_range(0, 3));
        return v[TIME_W-1:0];
    endfunction

    // one beat on the command port, preceded by an idle gap when gap is positive
    task automatic send_item(input logic has, input logic [KEY_W-1:0] key,
                             input logic [COUNT_W-1:0] cnt,
                             input logic [TIME_W-1:0] tm, input logic eos,
                             input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start         = 1'b1;
        i_has_record  = has;
        i_track_key   = key;
        i_play_count  = cnt;
        i_last_played = tm;
        i_end_of_set  = eos;
        do @(posedge i_clk); while (busy);
        sb.take_track(has, key, cnt, tm, eos);
        item_beats++;
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending() != 0 || busy) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = v;
        @(posedge i_clk);
        sb.set_limit(v);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic random_run(input int len);
        logic has;
        logic eos;
        int   gap;
        for (int i = 0; i < len; i++) begin
            eos = (i == len - 1);
            has = ($urandom_range(0, 9) != 0);
            if (eos && $urandom_range(0, 4) == 0)
                has = 1'b0;
            gap = $urandom_range(0, 6);
            send_item(has, KEY_W'($urandom), draw_count(), draw_time(), eos, gap);
        end
    endtask

    initial begin
        int run_no;
        int phase;
        start         = 1'b0;
        i_has_record  = 1'b0;
        i_track_key   = '0;
        i_play_count  = '0;
        i_last_played = '0;
        i_end_of_set  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        item_beats    = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty runs, field extremes, ties, limit edges
        send_item(1'b0, '0, '0, '0, 1'b1, 0);
        send_item(1'b0, '1, COUNT_MAX, TIME_MAX, 1'b0, 0);
        send_item(1'b1, '1, '0, TIME_MAX, 1'b1, 1);
        send_item(1'b1, '0, 31'd1, '0, 1'b0, 0);
        send_item(1'b1, '1, COUNT_MAX, TIME_MAX, 1'b0, 0);
        send_item(1'b1, 12'd12, 31'd5, 63'd100, 1'b0, 2);
        send_item(1'b1, 12'd13, 31'd5, 63'd100, 1'b0, 0);
        send_item(1'b1, 12'd14, 31'd5, 63'd200, 1'b0, 0);
        send_item(1'b1, 12'd15, 31'd5, 63'd100, 1'b1, 0);
        write_limit(7'd0);
        send_item(1'b1, 12'd1, 31'd7, 63'd7, 1'b0, 0);
        send_item(1'b1, 12'd2, 31'd8, 63'd8, 1'b1, 0);
        write_limit(7'd127);
        send_item(1'b1, 12'd3, 31'd9, 63'd1, 1'b0, 0);
        send_item(1'b1, 12'd4, 31'd9, 63'd2, 1'b0, 0);
        send_item(1'b1, 12'd5, 31'd2, TIME_MAX, 1'b0, 3);
        send_item(1'b0, '0, '0, '0, 1'b1, 0);
        write_limit(7'd1);
        send_item(1'b1, 12'd6, 31'd3, 63'd3, 1'b0, 0);
        send_item(1'b1, 12'd7, 31'd4, 63'd0, 1'b1, 0);

        // random runs, limit changed every few runs, some runs overfill the store
        item_beats = 0;
        run_no = 0;
        phase = 0;
        while (item_beats < 380) begin
            if (run_no % 5 == 0) begin
                case (phase)
                    0: write_limit(7'd64);
                    1: write_limit(7'd0);
                    2: write_limit(7'd127);
                    3: write_limit(7'd65);
                    4: write_limit(7'd1);
                    5: write_limit(7'd10);
                    default: write_limit(LIMIT_W'($urandom_range(0, 127)));
                endcase
                phase++;
            end
            if ($urandom_range(0, 9) == 0)
                random_run($urandom_range(65, 80));
            else
                random_run($urandom_range(1, 12));
            run_no++;
        end

        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
